FILE: sv/ofa_pkg.sv
package ofa_pkg;

    localparam int SLOTS     = 4;
    localparam int CKPT_BITS = 4;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int OP_W   = 2;
    localparam int TAG_W  = 7;
    localparam int PC_W   = 32;
    localparam int CKPT_W = 4;

    localparam int FIELD_W = TAG_W + PC_W + CKPT_W;
    localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W   = DATA_W - FIELD_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [PC_W-1:0]      pc;
        logic [CKPT_BITS-1:0] ckpt;
    } slot_t;

    typedef slot_t [SLOTS-1:0] slot_vec_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [PC_W-1:0]   pc;
        logic [CKPT_W-1:0] ckpt;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [TAG_W-1:0]  tag;
        logic [PC_W-1:0]   pc;
        logic [CKPT_W-1:0] ckpt;
    } res_t;

    // wrap bit on top, index below
    function automatic logic tag_older(input logic [TAG_W-1:0] a, input logic [TAG_W-1:0] b);
        if (a[TAG_W-1] == b[TAG_W-1])
        begin
            return a[TAG_W-2:0] < b[TAG_W-2:0];
        end
        return a[TAG_W-2:0] > b[TAG_W-2:0];
    endfunction

endpackage

FILE: sv/ofa_update.sv
module ofa_update
    import ofa_pkg::*;
(
    input  slot_vec_t slots_in,
    input  req_t      req,
    output slot_vec_t slots_out,
    output logic      overflow
);

    slot_vec_t        packed_s;
    slot_vec_t        ins_s;
    slot_vec_t        clr_s;
    slot_t            new_s;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] pos;
    logic             scanning;

    always_comb
    begin
        packed_s = '0;
        cnt      = '0;
        for (int r = 0; r < SLOTS; r++)
        begin
            if (slots_in[r].valid)
            begin
                packed_s[cnt[IDX_W-1:0]] = slots_in[r];
                cnt = cnt + 1'b1;
            end
        end

        // place after the leading run of older entries
        pos      = '0;
        scanning = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (scanning && (CNT_W'(i) < cnt))
            begin
                if (tag_older(packed_s[i].tag, req.tag))
                begin
                    pos = pos + 1'b1;
                end
                else
                begin
                    scanning = 1'b0;
                end
            end
        end

        new_s.valid = 1'b1;
        new_s.tag   = req.tag;
        new_s.pc    = req.pc;
        new_s.ckpt  = CKPT_BITS'(req.ckpt);

        for (int i = 0; i < SLOTS; i++)
        begin
            if (CNT_W'(i) < pos)
            begin
                ins_s[i] = packed_s[i];
            end
            else if (CNT_W'(i) == pos)
            begin
                ins_s[i] = new_s;
            end
            else if (i > 0)
            begin
                ins_s[i] = packed_s[i-1];
            end
            else
            begin
                ins_s[i] = packed_s[i];
            end
        end

        clr_s = slots_in;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slots_in[i].valid && !tag_older(slots_in[i].tag, req.tag))
            begin
                clr_s[i].valid = 1'b0;
            end
        end

        overflow  = 1'b0;
        slots_out = slots_in;
        unique case (req.op)
            OP_INSERT:
            begin
                if (cnt == CNT_W'(SLOTS))
                begin
                    overflow = 1'b1;
                end
                else
                begin
                    slots_out = ins_s;
                end
            end
            OP_CLEAR:
            begin
                slots_out = clr_s;
            end
            default:
            begin
                slots_out = slots_in;
            end
        endcase
    end

endmodule

FILE: sv/ofa_select.sv
module ofa_select
    import ofa_pkg::*;
(
    input  slot_vec_t slots,
    output res_t      res
);

    slot_t best;
    logic  found;

    always_comb
    begin
        best  = '0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slots[i].valid && (!found || tag_older(slots[i].tag, best.tag)))
            begin
                best  = slots[i];
                found = 1'b1;
            end
        end
        res.found = found;
        res.tag   = best.tag;
        res.pc    = best.pc;
        res.ckpt  = CKPT_W'(best.ckpt);
    end

endmodule

FILE: sv/oldest_first_flush_arbiter.sv
// channel   dir  tdata (low bit up)                         tuser (low bit up)
// s_*       in   squash_tag[6:0] target_pc[38:7]            opcode[1:0]
//                checkpoint_id[42:39] zero pad[47:43]
// m_*       out  oldest_tag[6:0] oldest_pc[38:7]            found[0] overflow[1]
//                oldest_checkpoint[42:39] zero pad[47:43]
//
// One item per cycle while m_tready does not stall the output; an accepted item passes the
// input register, then update and oldest-first select into the result register.
// Reset empties all slots and both registers; the block is ready right after.
// A stall on m_tready holds the result; s_tready stays high while the input
// register can move on or is empty.
module oldest_first_flush_arbiter
    import ofa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,  // squash_tag, target_pc, checkpoint_id
    input  logic [OP_W-1:0]     s_tuser,  // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,  // oldest_tag, oldest_pc, oldest_checkpoint
    output logic [1:0]          m_tuser   // found, overflow
);

    logic              in_valid_reg;
    req_t              in_req_reg;
    slot_vec_t         slots_reg;
    slot_vec_t         slots_next;
    logic              overflow_next;
    res_t              res_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [1:0]        out_user_reg;
    logic              advance;
    req_t              s_req;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign s_req.op   = s_tuser;
    assign s_req.tag  = s_tdata[TAG_W-1:0];
    assign s_req.pc   = s_tdata[TAG_W+PC_W-1:TAG_W];
    assign s_req.ckpt = s_tdata[FIELD_W-1:TAG_W+PC_W];

    ofa_update u_update (
        .slots_in  (slots_reg),
        .req       (in_req_reg),
        .slots_out (slots_next),
        .overflow  (overflow_next)
    );

    ofa_select u_select (
        .slots (slots_next),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_req_reg    <= '0;
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    in_req_reg <= s_req;
                end
            end
            if (advance)
            begin
                slots_reg     <= slots_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {{PAD_W{1'b0}}, res_next.ckpt, res_next.pc, res_next.tag};
                out_user_reg  <= {overflow_next, res_next.found};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: sv/ofa_checker.sv
module ofa_checker
    import ofa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty result carries nonzero data");

    a_ovf_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("overflow reported with no request held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind oldest_first_flush_arbiter ofa_checker u_ofa_checker (.*);
